[sv/fbbq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-band equaliser package
// Shared widths, formats, item and status types for the equaliser blocks.
// ----------------------------------------------------------------------------
package fbbq_pkg;

  localparam int BANDS          = 4;
  localparam int BAND_W         = 2;
  localparam int COEFS_PER_BAND = 5;
  localparam int SLOT_W         = 3;

  localparam int SAMPLE_W   = 16;
  localparam int STAGE_W    = 24;
  localparam int STAGE_FRAC = 15;
  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 24;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;

  // One product of a coefficient and a stage value, and a sum of five of them.
  localparam int PROD_W = COEF_W + STAGE_W;
  localparam int ACC_W  = PROD_W + 3;

  // Right shift that brings the gain product back to sample format.
  localparam int GAIN_SHIFT = STAGE_FRAC + GAIN_FRAC - (SAMPLE_W - 1);

  localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(32'h0100_0000);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] MUTE_LEVEL = '0;

  // Slots of a section's coefficient set.
  localparam logic [SLOT_W-1:0] SLOT_B0 = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_B1 = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_B2 = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_A1 = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_A2 = SLOT_W'(4);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_STAGE,
    ST_GAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BAND_W-1:0]          band;
    logic [SLOT_W-1:0]          slot;
    logic [COEF_W-1:0]          value;
    logic                       block_end;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic idle;
    logic emit;
  } back_stat_t;

endpackage

[sv/fbbq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equaliser front end
// Accepts input transactions, classifies them and drops invalid writes.
// ----------------------------------------------------------------------------
module fbbq_front
  import fbbq_pkg::*;
(
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [BAND_W-1:0]          coef_band,
  input  logic [SLOT_W-1:0]          coef_slot,
  input  logic signed [COEF_W-1:0]   coef_value,
  input  logic                       block_end,
  input  q_stat_t                    q_stat,
  output logic                       q_push,
  output item_t                      q_item
);

  logic accept;
  logic keep;
  op_t  op;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign op       = command ? OP_LOAD : OP_FILTER;

  // A write to a slot or band that does not exist is taken and forgotten.
  always_comb begin
    unique case (op)
      OP_LOAD:   keep = (coef_slot < SLOT_W'(COEFS_PER_BAND)) &&
                        ({1'b0, coef_band} < (BAND_W + 1)'(BANDS));
      OP_FILTER: keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign q_push           = accept && keep;
  assign q_item.op        = op;
  assign q_item.sample    = sample_in;
  assign q_item.band      = coef_band;
  assign q_item.slot      = coef_slot;
  assign q_item.value     = coef_value;
  assign q_item.block_end = block_end;

endmodule

[sv/fbbq_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equaliser item queue
// Two-entry queue between the front end and the filter engine.
// ----------------------------------------------------------------------------
module fbbq_queue
  import fbbq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t stat
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[sv/fbbq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equaliser filter engine
// Runs queued items through the biquad cascade on one shared multiplier.
// ----------------------------------------------------------------------------
module fbbq_back
  import fbbq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  item_t                      head,
  input  q_stat_t                    q_stat,
  output logic                       pop,
  input  logic [GAIN_W-1:0]          gain,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       block_end_out,
  output back_stat_t                 stat
);

  localparam int STAGE_SH_W = ACC_W - COEF_FRAC;
  localparam int GAIN_SH_W  = PROD_W - GAIN_SHIFT;
  localparam logic signed [ACC_W-1:0]  STAGE_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [PROD_W-1:0] GAIN_HALF  = PROD_W'(1) << (GAIN_SHIFT - 1);

  state_t state;
  state_t state_next;

  logic signed [COEF_W-1:0]  coef [BANDS][COEFS_PER_BAND];
  logic signed [STAGE_W-1:0] xh [BANDS][2];
  logic signed [STAGE_W-1:0] yh [BANDS][2];

  logic [BAND_W-1:0]         band;
  logic [SLOT_W-1:0]         step;
  logic signed [STAGE_W-1:0] x_cur;
  logic                      mark;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_neg;
  logic signed [ACC_W-1:0]   acc;

  logic signed [COEF_W-1:0]     mul_a;
  logic signed [STAGE_W-1:0]    mul_b;
  logic signed [STAGE_W-1:0]    hist_op;
  logic signed [ACC_W-1:0]      acc_sum;
  logic signed [ACC_W-1:0]      stage_rnd;
  logic [STAGE_SH_W-1:0]        stage_sh;
  logic signed [STAGE_W-1:0]    stage_y;
  logic signed [PROD_W-1:0]     gain_rnd;
  logic [GAIN_SH_W-1:0]         gain_sh;
  logic signed [SAMPLE_W-1:0]   gain_y;
  logic                         out_free;
  logic                         out_load;
  logic                         last_band;

  assign last_band = (band == BAND_W'(BANDS - 1));
  assign out_free  = !out_valid || !out_stall;

  // Operand taken from the section's history for the current tap.
  always_comb begin
    unique case (step)
      SLOT_B0: hist_op = x_cur;
      SLOT_B1: hist_op = xh[band][0];
      SLOT_B2: hist_op = xh[band][1];
      SLOT_A1: hist_op = yh[band][0];
      SLOT_A2: hist_op = yh[band][1];
      default: hist_op = '0;
    endcase
  end

  always_comb begin
    if (state == ST_GAIN) begin
      mul_a = {{(COEF_W - GAIN_W){1'b0}}, gain};
      mul_b = x_cur;
    end else begin
      mul_a = coef[band][step];
      mul_b = hist_op;
    end
  end

  assign acc_sum = prod_neg ? acc - ACC_W'(prod) : acc + ACC_W'(prod);

  // Round half up, then saturate to the stage width.
  assign stage_rnd = acc + STAGE_HALF;
  assign stage_sh  = stage_rnd[ACC_W-1:COEF_FRAC];
  always_comb begin
    if ((&stage_sh[STAGE_SH_W-1:STAGE_W-1]) || !(|stage_sh[STAGE_SH_W-1:STAGE_W-1])) begin
      stage_y = stage_sh[STAGE_W-1:0];
    end else if (stage_sh[STAGE_SH_W-1]) begin
      stage_y = {1'b1, {(STAGE_W - 1){1'b0}}};
    end else begin
      stage_y = {1'b0, {(STAGE_W - 1){1'b1}}};
    end
  end

  assign gain_rnd = prod + GAIN_HALF;
  assign gain_sh  = gain_rnd[PROD_W-1:GAIN_SHIFT];
  always_comb begin
    if (gain <= MUTE_LEVEL) begin
      gain_y = '0;
    end else if ((&gain_sh[GAIN_SH_W-1:SAMPLE_W-1]) ||
                 !(|gain_sh[GAIN_SH_W-1:SAMPLE_W-1])) begin
      gain_y = gain_sh[SAMPLE_W-1:0];
    end else if (gain_sh[GAIN_SH_W-1]) begin
      gain_y = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      gain_y = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (head.op == OP_FILTER) begin
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (step == SLOT_A2) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_STAGE;
      ST_STAGE: state_next = last_band ? ST_GAIN : ST_MAC;
      ST_GAIN:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.emit = out_load;

  // Datapath sequencing.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        band  <= '0;
        step  <= '0;
        x_cur <= STAGE_W'(head.sample);
        mark  <= head.block_end;
      end
      ST_MAC: begin
        prod     <= PROD_W'(mul_a) * PROD_W'(mul_b);
        prod_neg <= (step >= SLOT_A1);
        acc      <= (step == SLOT_B0) ? '0 : acc_sum;
        if (step != SLOT_A2) begin
          step <= step + 1'b1;
        end
      end
      ST_DRAIN: acc <= acc_sum;
      ST_STAGE: begin
        x_cur <= stage_y;
        step  <= '0;
        band  <= band + 1'b1;
      end
      ST_GAIN: prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      ST_EMIT: ;
      default: ;
    endcase
  end

  // Coefficients and section histories; reset gives a passthrough cascade.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANDS; b++) begin
        for (int s = 0; s < COEFS_PER_BAND; s++) begin
          coef[b][s] <= (s == 0) ? COEF_ONE : '0;
        end
        xh[b][0] <= '0;
        xh[b][1] <= '0;
        yh[b][0] <= '0;
        yh[b][1] <= '0;
      end
    end else begin
      if (pop && head.op == OP_LOAD) begin
        coef[head.band][head.slot] <= head.value;
      end
      if (state == ST_STAGE) begin
        xh[band][1] <= xh[band][0];
        xh[band][0] <= x_cur;
        yh[band][1] <= yh[band][0];
        yh[band][0] <= stage_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out    <= gain_y;
      block_end_out <= mark;
    end
  end

endmodule

[sv/four_band_biquad_equalizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-band biquad equaliser
// Four cascaded direct-form-1 biquad sections followed by an output gain.
// ----------------------------------------------------------------------------
// The input channel carries two kinds of transaction. A filter transaction
// (command low) delivers one Q1.15 sample, and exactly one output
// transaction follows with the equalised, gain-scaled sample and a copy of
// its block_end mark. A coefficient transaction (command high) loads one
// Q8.24 coefficient of one section and produces no output; writes to a
// slot beyond a2 are dropped.
// Both channels use valid and stall. Input transactions enter a two-entry
// queue, so the input is stalled only while that queue is full.
// The engine uses one multiplier for all twenty products of a sample and
// for the gain, so it works on a sample in steps: it collects it, runs
// each section through five taps, a drain of the accumulator and a round
// and saturate, then applies the gain and emits the result. It takes no
// new item until that sample is done; a coefficient write is taken while
// the engine is idle and leaves it idle.
// When the receiver stalls, the result is held in the output register and
// the engine waits in its last step; the queue keeps taking input.
// Reset restores passthrough coefficients, clears all histories and sets the
// output gain to unity. The user must write the gain register (cfg_write,
// cfg_data) only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module four_band_biquad_equalizer
  import fbbq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [GAIN_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [BAND_W-1:0]          coef_band,
  input  logic [SLOT_W-1:0]          coef_slot,
  input  logic signed [COEF_W-1:0]   coef_value,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       block_end_out
);

  // Output gain, unsigned Q1.15.
  logic [GAIN_W-1:0] output_gain;

  logic       q_push;
  logic       q_pop;
  item_t      q_item;
  item_t      q_head;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_gain <= GAIN_RESET;
    end else if (cfg_write) begin
      output_gain <= cfg_data;
    end
  end

  // The front end decodes each transaction and pushes it into the queue.
  fbbq_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .sample_in  (sample_in),
    .coef_band  (coef_band),
    .coef_slot  (coef_slot),
    .coef_value (coef_value),
    .block_end  (block_end),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  fbbq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // The engine takes one item at a time from the head of the queue.
  fbbq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_stat        (q_stat),
    .pop           (q_pop),
    .gain          (output_gain),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .block_end_out (block_end_out),
    .stat          (b_stat)
  );

`ifndef ASSERT_OFF
  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("item pushed into a full queue");

  // The engine takes items only when idle and only from a non-empty queue.
  a_pop_legal: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (b_stat.idle && !q_stat.empty))
    else $error("queue popped while empty or while the engine was busy");

  // A new result appears only from the engine's final step.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_stat.emit))
    else $error("output valid raised without a finished sample");
`endif

endmodule
